// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Clocked property, also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ----- sv/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [7:0] END_CHAR = 8'h00;

  // Job queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // Bytes released by one character: byte0 goes out first, cnt is 1..3
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
  } job_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ----- sv/b64d_front.sv -----
// ----------------------------------------------------------------------------
// b64d_front
// Classifies each character, updates the accumulator and emits a job with
// the bytes the character releases.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       text_char_i,
  output logic             in_ready_o,
  input  logic             q_full_i,
  output logic             push_o,
  output b64d_pkg::job_t   job_o
);

  // Sextet decode: bit 6 set when the character is in the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      sextet_of = {1'b1, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h47;
      sextet_of = {1'b1, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'h04;
      sextet_of = {1'b1, d[5:0]};
    end else if (c == 8'h2B) begin
      sextet_of = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      sextet_of = {1'b1, 6'd63};
    end else begin
      sextet_of = {1'b0, d[5:0]};
    end
  endfunction

  logic [23:0]    acc_q, acc_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           pad_q, pad_d;
  logic           accept;
  logic [6:0]     sx;
  logic [23:0]    acc_sh;
  b64d_pkg::job_t flush_job;
  logic           flush_any;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign sx         = sextet_of(text_char_i);
  assign acc_sh     = {acc_q[17:0], sx[5:0]};

  // Tail flush of two or three pending characters
  always_comb begin
    flush_job.bytes = {8'd0, acc_q[9:2], acc_q[17:10]};
    flush_job.cnt   = 2'd2;
    flush_any       = 1'b1;
    case (cnt_q)
      2'd2: begin
        flush_job.bytes = {8'd0, 8'd0, acc_q[11:4]};
        flush_job.cnt   = 2'd1;
      end
      2'd3: begin
        flush_job.bytes = {8'd0, acc_q[9:2], acc_q[17:10]};
        flush_job.cnt   = 2'd2;
      end
      default: begin
        flush_any = 1'b0;
      end
    endcase
  end

  // Character classification and next state
  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    pad_d  = pad_q;
    job_o  = flush_job;
    push_o = 1'b0;
    if (accept) begin
      if (text_char_i == b64d_pkg::END_CHAR) begin
        push_o = flush_any && !pad_q;
        acc_d  = 24'd0;
        cnt_d  = 2'd0;
        pad_d  = 1'b0;
      end else if (pad_q) begin
        push_o = 1'b0;
      end else if (text_char_i == b64d_pkg::PAD_CHAR) begin
        push_o = flush_any;
        acc_d  = 24'd0;
        cnt_d  = 2'd0;
        pad_d  = 1'b1;
      end else if (sx[6]) begin
        if (cnt_q == 2'd3) begin
          job_o.bytes = {acc_sh[7:0], acc_sh[15:8], acc_sh[23:16]};
          job_o.cnt   = 2'd3;
          push_o      = 1'b1;
          acc_d       = 24'd0;
          cnt_d       = 2'd0;
        end else begin
          acc_d = acc_sh;
          cnt_d = cnt_q + 2'd1;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 24'd0;
      cnt_q <= 2'd0;
      pad_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      pad_q <= pad_d;
    end
  end

endmodule

// ----- sv/b64d_fifo.sv -----
// ----------------------------------------------------------------------------
// b64d_fifo
// Short job queue that decouples the front end from the byte output.
// ----------------------------------------------------------------------------
module b64d_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  b64d_pkg::job_t        job_i,
  input  logic                  pop_i,
  output b64d_pkg::job_t        job_o,
  output b64d_pkg::q_status_t   status_o
);

  localparam int unsigned CNT_W = b64d_pkg::QPTR_W + 1;

  b64d_pkg::job_t                  mem_q [b64d_pkg::QDEPTH];
  logic [b64d_pkg::QPTR_W-1:0]     wptr_q, rptr_q;
  logic [CNT_W-1:0]                cnt_q;
  logic                            do_push, do_pop;

  assign status_o.empty = (cnt_q == CNT_W'(0));
  assign status_o.full  = (cnt_q == CNT_W'(b64d_pkg::QDEPTH));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign job_o          = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ----- sv/b64d_back.sv -----
// ----------------------------------------------------------------------------
// b64d_back
// Holds one job and sends its bytes out one per cycle while out_ready_i is high, flagging the last.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  b64d_pkg::job_t       job_i,
  input  b64d_pkg::q_status_t  q_status_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 run_last_o
);

  b64d_pkg::job_t job_q;
  logic [1:0]     idx_q;
  logic           valid_q;
  logic           load;

  assign out_valid_o = valid_q;
  assign run_last_o  = (idx_q == job_q.cnt - 2'd1);
  assign load        = !valid_q || (out_ready_i && run_last_o);
  assign pop_o       = load && !q_status_i.empty;

  // Byte select
  always_comb begin
    case (idx_q)
      2'd0:    out_byte_o = job_q.bytes[0];
      2'd1:    out_byte_o = job_q.bytes[1];
      2'd2:    out_byte_o = job_q.bytes[2];
      default: out_byte_o = job_q.bytes[0];
    endcase
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load) begin
      valid_q <= !q_status_i.empty;
      idx_q   <= 2'd0;
    end else if (out_ready_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  // Job payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

endmodule

// ----- sv/base64_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Base64 text decoder: one character in per item, decoded bytes out.
// ----------------------------------------------------------------------------
//  channel | signals                               | item
//  --------+---------------------------------------+---------------------------
//  in      | in_valid_i, in_ready_o, text_char_i   | one character code
//  out     | out_valid_o, out_ready_i, out_byte_o, | one byte, run_last_o marks
//          | run_last_o                            | the last of its character
//
// One character is taken per cycle while the two-entry job queue has room.
// Output runs at one byte per cycle while out_ready_i is high, so a full group
// of four characters yields three bytes from the output stage.
// Input reaches the output through the job queue and then the output stage.
// Reset clears the accumulator, pending count, pad flag, queue and output.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);

  b64d_pkg::job_t      push_job, pop_job;
  b64d_pkg::q_status_t q_status;
  logic                push, pop;

  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .text_char_i (text_char_i),
    .in_ready_o  (in_ready_o),
    .q_full_i    (q_status.full),
    .push_o      (push),
    .job_o       (push_job)
  );

  b64d_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .job_o    (pop_job),
    .status_o (q_status)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule

// ----- sv/b64d_checker.sv -----
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks of the base64 stream decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       run_last_o
);

  logic out_stall;

  assign out_stall = out_valid_o && !out_ready_i;

  // Stalled output item holds
  `ASSERT_CLKD(a_out_hold, clk_i, rst_ni, out_stall |=> $stable({out_valid_o, out_byte_o, run_last_o}))

  // Bytes of one character leave back to back
  `ASSERT_CLKD(a_run_cont, clk_i, rst_ni, out_valid_o && out_ready_i && !run_last_o |=> out_valid_o)

  // Input only stalls behind a waiting output
  `ASSERT_CLKD(a_stall_cause, clk_i, rst_ni, !in_ready_o |-> out_valid_o)

  // Nothing is offered during reset
  `ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |-> !out_valid_o)

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .run_last_o  (run_last_o)
);
